FILE: design/cfl_pkg.sv
// ----------------------------------------------------------------------------
// cfl_pkg
// Shared types for the camera frame builder: the front-to-back record.
// ----------------------------------------------------------------------------
package cfl_pkg;

  // signs of the look vector components, as the front part leaves them
  typedef struct packed {
    logic [2:0] neg;
  } cfl_class_t;

endpackage

FILE: design/cfl_front.sv
// ----------------------------------------------------------------------------
// cfl_front
// Input register stage: takes a pose request and splits the look vector into
// magnitudes and signs.
// ----------------------------------------------------------------------------
module cfl_front
  import cfl_pkg::*;
#(
  parameter int unsigned IN_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic [IN_WIDTH-1:0] pos_x_i,
  input  logic [IN_WIDTH-1:0] pos_y_i,
  input  logic [IN_WIDTH-1:0] pos_z_i,
  input  logic [IN_WIDTH-1:0] look_x_i,
  input  logic [IN_WIDTH-1:0] look_y_i,
  input  logic [IN_WIDTH-1:0] look_z_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [IN_WIDTH-1:0] pos_o [3],
  output logic [IN_WIDTH-1:0] mag_o [3],
  output cfl_class_t          cls_o
);

  logic                valid_q;
  logic [IN_WIDTH-1:0] pos_q [3];
  logic [IN_WIDTH-1:0] mag_q [3];
  cfl_class_t          cls_q;
  logic [IN_WIDTH-1:0] look [3];
  logic [IN_WIDTH-1:0] mag_d [3];
  logic                load;

  assign look[0] = look_x_i;
  assign look[1] = look_y_i;
  assign look[2] = look_z_i;
  assign stall_o = valid_q && stall_i;
  assign load    = valid_i && !stall_o;

  // magnitude of each component, most negative value stays exact as unsigned
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = look[i][IN_WIDTH-1] ? (~look[i] + 1'b1) : look[i];
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      mag_q <= mag_d;
      cls_q.neg <= {look_z_i[IN_WIDTH-1], look_y_i[IN_WIDTH-1], look_x_i[IN_WIDTH-1]};
    end
  end

  assign valid_o = valid_q;
  assign pos_o   = pos_q;
  assign mag_o   = mag_q;
  assign cls_o   = cls_q;

endmodule

FILE: design/cfl_back.sv
// ----------------------------------------------------------------------------
// cfl_back
// Arithmetic pipeline: squared norm, bit-per-stage square root, radix-2
// restoring dividers unrolled one bit per stage, cross product and rounding.
// A stall freezes every stage; an empty front register still takes a request.
// ----------------------------------------------------------------------------
module cfl_back
  import cfl_pkg::*;
#(
  parameter int unsigned IN_WIDTH       = 32,
  parameter int unsigned UNIT_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [IN_WIDTH-1:0]       pos_i [3],
  input  logic [IN_WIDTH-1:0]       mag_i [3],
  input  cfl_class_t                cls_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [UNIT_FRAC_BITS+1:0] right_o [2],
  output logic [UNIT_FRAC_BITS+1:0] fwd_o [3],
  output logic [UNIT_FRAC_BITS+1:0] up_o [3],
  output logic [IN_WIDTH-1:0]       trans_o [3]
);

  localparam int unsigned F  = UNIT_FRAC_BITS;
  localparam int unsigned UW = F + 2;
  localparam int unsigned SW = 2 * IN_WIDTH + 2;      // sum of three squares
  localparam int unsigned RW = IN_WIDTH + 1;          // root width
  localparam int unsigned NW = IN_WIDTH + F;          // dividend width
  localparam int unsigned RUW = F + 2;                // right root width
  localparam int unsigned RSW = 2 * F + 3;            // right sum width
  localparam int unsigned RNW = F + 1 + F;            // right dividend width
  // stage layout
  localparam int unsigned S_SQ   = 2;                 // products, then sum
  localparam int unsigned S_RT   = RW;                // one root bit per stage
  localparam int unsigned S_DV   = NW;                // one quotient bit per stage
  localparam int unsigned S_RD   = 1;                 // rounding, sign
  localparam int unsigned S_R2   = 2 + RUW + RNW + 1;
  localparam int unsigned S_UP   = 2;
  localparam int unsigned DEPTH  = S_SQ + S_RT + S_DV + S_RD + S_R2 + S_UP;

  // pipeline-wide advance
  logic adv;
  logic [DEPTH-1:0] vld_q;
  assign adv     = !(vld_q[DEPTH-1] && stall_i);
  assign stall_o = !adv;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], valid_i};
    end
  end

  // ---------------- forward norm and quotient ------------------------------
  // squares
  logic [2*IN_WIDTH-1:0] sq_q [3];
  logic [IN_WIDTH-1:0]   m1_q [3];
  logic [IN_WIDTH-1:0]   p1_q [3];
  cfl_class_t            c1_q;
  logic [SW-1:0]         s2_q;
  logic [IN_WIDTH-1:0]   m2_q [3];
  logic [IN_WIDTH-1:0]   p2_q [3];
  cfl_class_t            c2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= mag_i[i] * mag_i[i];
      end
      m1_q <= mag_i; p1_q <= pos_i; c1_q <= cls_i;
      s2_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      m2_q <= m1_q; p2_q <= p1_q; c2_q <= c1_q;
    end
  end

  // square root: restoring digit recurrence, one bit per stage
  logic [SW-1:0]       rt_rem_q [S_RT+1];
  logic [RW-1:0]       rt_res_q [S_RT+1];
  logic [SW-1:0]       rt_val_q [S_RT+1];
  logic [IN_WIDTH-1:0] rt_mag_q [S_RT+1][3];
  logic [IN_WIDTH-1:0] rt_pos_q [S_RT+1][3];
  cfl_class_t          rt_cls_q [S_RT+1];

  always_comb begin
    rt_rem_q[0] = '0;
    rt_res_q[0] = '0;
    rt_val_q[0] = s2_q;
    rt_mag_q[0] = m2_q;
    rt_pos_q[0] = p2_q;
    rt_cls_q[0] = c2_q;
  end

  for (genvar k = 0; k < S_RT; k++) begin : g_root
    localparam int unsigned B = S_RT - 1 - k;
    logic [SW+1:0] rem2;
    logic [SW+1:0] trial;
    always_comb begin
      rem2  = {rt_rem_q[k], rt_val_q[k][2*B+1 -: 2]};
      trial = {(SW+2-RW-2)'(0), rt_res_q[k], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rem2 >= trial) begin
          rt_rem_q[k+1] <= SW'(rem2 - trial);
          rt_res_q[k+1] <= {rt_res_q[k][RW-2:0], 1'b1};
        end else begin
          rt_rem_q[k+1] <= SW'(rem2);
          rt_res_q[k+1] <= {rt_res_q[k][RW-2:0], 1'b0};
        end
        rt_val_q[k+1] <= rt_val_q[k];
        rt_mag_q[k+1] <= rt_mag_q[k];
        rt_pos_q[k+1] <= rt_pos_q[k];
        rt_cls_q[k+1] <= rt_cls_q[k];
      end
    end
  end

  // divide mag*2^F by the floored norm, one quotient bit per stage
  logic [RW-1:0]       dv_den_q [S_DV+1];
  logic [RW:0]         dv_rem_q [S_DV+1][3];
  logic [NW-1:0]       dv_num_q [S_DV+1][3];
  logic [IN_WIDTH-1:0] dv_pos_q [S_DV+1][3];
  cfl_class_t          dv_cls_q [S_DV+1];

  always_comb begin
    dv_den_q[0] = (rt_res_q[S_RT] == '0) ? RW'(1) : rt_res_q[S_RT];
    for (int i = 0; i < 3; i++) begin
      dv_rem_q[0][i] = '0;
      dv_num_q[0][i] = {rt_mag_q[S_RT][i], F'(0)};
    end
    dv_pos_q[0] = rt_pos_q[S_RT];
    dv_cls_q[0] = rt_cls_q[S_RT];
  end

  for (genvar k = 0; k < S_DV; k++) begin : g_fdiv
    logic [RW:0] r2 [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {dv_rem_q[k][i][RW-1:0], dv_num_q[k][i][NW-1]};
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          if (r2[i] >= {1'b0, dv_den_q[k]}) begin
            dv_rem_q[k+1][i] <= r2[i] - {1'b0, dv_den_q[k]};
            dv_num_q[k+1][i] <= {dv_num_q[k][i][NW-2:0], 1'b1};
          end else begin
            dv_rem_q[k+1][i] <= r2[i];
            dv_num_q[k+1][i] <= {dv_num_q[k][i][NW-2:0], 1'b0};
          end
        end
        dv_den_q[k+1] <= dv_den_q[k];
        dv_pos_q[k+1] <= dv_pos_q[k];
        dv_cls_q[k+1] <= dv_cls_q[k];
      end
    end
  end

  // rounding of the forward quotients, clamp to one, apply sign
  logic [UW-1:0]       f_q [3];
  logic [IN_WIDTH-1:0] fp_q [3];
  logic [UW-1:0]       f_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [NW:0] q;
      logic [RW:0] rem_twice;
      q = {1'b0, dv_num_q[S_DV][i]};
      rem_twice = {dv_rem_q[S_DV][i][RW-1:0], 1'b0};
      if (rem_twice >= {1'b0, dv_den_q[S_DV]}) begin
        q = q + 1'b1;
      end
      if (q > (NW+1)'(1 << F)) begin
        q = (NW+1)'(1 << F);
      end
      f_d[i] = dv_cls_q[S_DV].neg[i] ? UW'(~q[UW-1:0] + 1'b1) : q[UW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_q  <= f_d;
      fp_q <= dv_pos_q[S_DV];
    end
  end

  // ---------------- right vector: (fy, -fx) normalized --------------------
  // squares of forward x and y, then sum
  logic [UW-1:0]       ra_mag_q [2];
  logic [1:0]          ra_neg_q;
  logic [2*UW-1:0]     ra_sq_q [2];
  logic [UW-1:0]       ra_f_q [3];
  logic [IN_WIDTH-1:0] ra_p_q [3];
  logic [RSW-1:0]      rb_s_q;
  logic [UW-1:0]       rb_mag_q [2];
  logic [1:0]          rb_neg_q;
  logic [UW-1:0]       rb_f_q [3];
  logic [IN_WIDTH-1:0] rb_p_q [3];
  logic [UW-1:0]       ra_mag_d [2];

  always_comb begin
    ra_mag_d[0] = f_q[1][UW-1] ? UW'(~f_q[1] + 1'b1) : f_q[1];
    ra_mag_d[1] = f_q[0][UW-1] ? UW'(~f_q[0] + 1'b1) : f_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ra_mag_q <= ra_mag_d;
      ra_neg_q <= {(!f_q[0][UW-1] && f_q[0] != '0), f_q[1][UW-1]};
      ra_sq_q[0] <= ra_mag_d[0] * ra_mag_d[0];
      ra_sq_q[1] <= ra_mag_d[1] * ra_mag_d[1];
      ra_f_q <= f_q;
      ra_p_q <= fp_q;
      rb_s_q <= RSW'(ra_sq_q[0]) + RSW'(ra_sq_q[1]);
      rb_mag_q <= ra_mag_q;
      rb_neg_q <= ra_neg_q;
      rb_f_q <= ra_f_q;
      rb_p_q <= ra_p_q;
    end
  end

  // right norm square root
  logic [RSW-1:0]      qr_rem_q [RUW+1];
  logic [RUW-1:0]      qr_res_q [RUW+1];
  logic [RSW-1:0]      qr_val_q [RUW+1];
  logic [UW-1:0]       qr_mag_q [RUW+1][2];
  logic [1:0]          qr_neg_q [RUW+1];
  logic [UW-1:0]       qr_f_q [RUW+1][3];
  logic [IN_WIDTH-1:0] qr_p_q [RUW+1][3];

  always_comb begin
    qr_rem_q[0] = '0;
    qr_res_q[0] = '0;
    qr_val_q[0] = rb_s_q;
    qr_mag_q[0] = rb_mag_q;
    qr_neg_q[0] = rb_neg_q;
    qr_f_q[0]   = rb_f_q;
    qr_p_q[0]   = rb_p_q;
  end

  for (genvar k = 0; k < RUW; k++) begin : g_rroot
    localparam int unsigned B = RUW - 1 - k;
    logic [RSW+1:0] rem2;
    logic [RSW+1:0] trial;
    logic [RSW+2:0] val_x;
    always_comb begin
      val_x = {2'b00, qr_val_q[k]};
      rem2  = {qr_rem_q[k], val_x[2*B+1 -: 2]};
      trial = {(RSW+2-RUW-2)'(0), qr_res_q[k], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rem2 >= trial) begin
          qr_rem_q[k+1] <= RSW'(rem2 - trial);
          qr_res_q[k+1] <= {qr_res_q[k][RUW-2:0], 1'b1};
        end else begin
          qr_rem_q[k+1] <= RSW'(rem2);
          qr_res_q[k+1] <= {qr_res_q[k][RUW-2:0], 1'b0};
        end
        qr_val_q[k+1] <= qr_val_q[k];
        qr_mag_q[k+1] <= qr_mag_q[k];
        qr_neg_q[k+1] <= qr_neg_q[k];
        qr_f_q[k+1]   <= qr_f_q[k];
        qr_p_q[k+1]   <= qr_p_q[k];
      end
    end
  end

  // right divide, one bit per stage
  logic [RUW-1:0]      rd_den_q [RNW+1];
  logic [RUW:0]        rd_rem_q [RNW+1][2];
  logic [RNW-1:0]      rd_num_q [RNW+1][2];
  logic [1:0]          rd_neg_q [RNW+1];
  logic [UW-1:0]       rd_f_q [RNW+1][3];
  logic [IN_WIDTH-1:0] rd_p_q [RNW+1][3];

  always_comb begin
    rd_den_q[0] = (qr_res_q[RUW] == '0) ? RUW'(1) : qr_res_q[RUW];
    for (int i = 0; i < 2; i++) begin
      rd_rem_q[0][i] = '0;
      rd_num_q[0][i] = {qr_mag_q[RUW][i][F:0], F'(0)};
    end
    rd_neg_q[0] = qr_neg_q[RUW];
    rd_f_q[0]   = qr_f_q[RUW];
    rd_p_q[0]   = qr_p_q[RUW];
  end

  for (genvar k = 0; k < RNW; k++) begin : g_rdiv
    logic [RUW:0] r2 [2];
    always_comb begin
      for (int i = 0; i < 2; i++) begin
        r2[i] = {rd_rem_q[k][i][RUW-1:0], rd_num_q[k][i][RNW-1]};
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < 2; i++) begin
          if (r2[i] >= {1'b0, rd_den_q[k]}) begin
            rd_rem_q[k+1][i] <= r2[i] - {1'b0, rd_den_q[k]};
            rd_num_q[k+1][i] <= {rd_num_q[k][i][RNW-2:0], 1'b1};
          end else begin
            rd_rem_q[k+1][i] <= r2[i];
            rd_num_q[k+1][i] <= {rd_num_q[k][i][RNW-2:0], 1'b0};
          end
        end
        rd_den_q[k+1] <= rd_den_q[k];
        rd_neg_q[k+1] <= rd_neg_q[k];
        rd_f_q[k+1]   <= rd_f_q[k];
        rd_p_q[k+1]   <= rd_p_q[k];
      end
    end
  end

  // right rounding, clamp to one and sign
  logic [UW-1:0]       r_q [2];
  logic [UW-1:0]       rf_q [3];
  logic [IN_WIDTH-1:0] rp_q [3];
  logic [UW-1:0]       r_d [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      logic [RNW:0] q;
      logic [RUW:0] rem_twice;
      q = {1'b0, rd_num_q[RNW][i]};
      rem_twice = {rd_rem_q[RNW][i][RUW-1:0], 1'b0};
      if (rem_twice >= {1'b0, rd_den_q[RNW]}) begin
        q = q + 1'b1;
      end
      if (q > (RNW+1)'(1 << F)) begin
        q = (RNW+1)'(1 << F);
      end
      r_d[i] = rd_neg_q[RNW][i] ? UW'(~q[UW-1:0] + 1'b1) : q[UW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q  <= r_d;
      rf_q <= rd_f_q[RNW];
      rp_q <= rd_p_q[RNW];
    end
  end

  // ---------------- up = right x forward ----------------------------------
  localparam int unsigned PW = 2 * UW + 1;
  logic signed [PW-1:0] pr_q [4];
  logic [UW-1:0]        ur_q [2];
  logic [UW-1:0]        uf_q [3];
  logic [IN_WIDTH-1:0]  up_p_q [3];
  logic [UW-1:0]        up_q [3];
  logic [UW-1:0]        or_q [2];
  logic [UW-1:0]        of_q [3];
  logic [IN_WIDTH-1:0]  op_q [3];
  logic signed [PW-1:0] upw [3];
  logic [UW-1:0]        up_d [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q[0] <= PW'($signed(r_q[1]) * $signed(rf_q[2]));
      pr_q[1] <= PW'($signed(r_q[0]) * $signed(rf_q[2]));
      pr_q[2] <= PW'($signed(r_q[0]) * $signed(rf_q[1]));
      pr_q[3] <= PW'($signed(r_q[1]) * $signed(rf_q[0]));
      ur_q <= r_q; uf_q <= rf_q; up_p_q <= rp_q;
    end
  end

  always_comb begin
    upw[0] = pr_q[0];
    upw[1] = -pr_q[1];
    upw[2] = pr_q[2] - pr_q[3];
    for (int i = 0; i < 3; i++) begin
      logic [PW-1:0] m;
      m = upw[i][PW-1] ? PW'(-upw[i]) : PW'(upw[i]);
      m = (m + PW'(1 << (F - 1))) >> F;
      if (m > PW'(1 << F)) begin
        m = PW'(1 << F);
      end
      up_d[i] = upw[i][PW-1] ? UW'(~m[UW-1:0] + 1'b1) : m[UW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      up_q <= up_d; or_q <= ur_q; of_q <= uf_q; op_q <= up_p_q;
    end
  end

  assign valid_o = vld_q[DEPTH-1];
  assign right_o = or_q;
  assign fwd_o   = of_q;
  assign up_o    = up_q;
  assign trans_o = op_q;

endmodule

FILE: design/camera_frame_from_lookdir_top.sv
// ----------------------------------------------------------------------------
// camera_frame_from_lookdir_top
// Camera pose builder: forward, right, up unit columns and translation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: valid_i/stall_o with position and look direction, Q16.16.
//   Output channel: valid_o/stall_i with the 3x4 pose, unit columns Q1.F.
//   Throughput: one transaction per cycle while the receiver does not stall;
//   the roots and divides are unrolled, so a new pose can enter each cycle.
//   Order: the front register, then the back pipeline: squares and their
//   sum, root and divide stages and rounding for the forward norm, the same
//   again for the right norm, then the cross product and its rounding.
//   Stall: a receiver stall with valid_o high holds the whole back pipeline;
//   an empty front register takes one more transaction, then stall_o rises.
//   Reset: clears all valid bits; payload is not reset. No pending data.
//   Zero look direction gives zero unit columns, a vertical one zero right
//   and up columns.
// ----------------------------------------------------------------------------
module camera_frame_from_lookdir_top
  import cfl_pkg::*;
#(
  parameter int unsigned IN_WIDTH       = 32,
  parameter int unsigned UNIT_FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             stall_o,
  input  logic signed [IN_WIDTH-1:0]       pos_x_i,
  input  logic signed [IN_WIDTH-1:0]       pos_y_i,
  input  logic signed [IN_WIDTH-1:0]       pos_z_i,
  input  logic signed [IN_WIDTH-1:0]       look_x_i,
  input  logic signed [IN_WIDTH-1:0]       look_y_i,
  input  logic signed [IN_WIDTH-1:0]       look_z_i,
  output logic                             valid_o,
  input  logic                             stall_i,
  output logic signed [UNIT_FRAC_BITS+1:0] right_x_o,
  output logic signed [UNIT_FRAC_BITS+1:0] right_y_o,
  output logic                             right_z_o,
  output logic signed [UNIT_FRAC_BITS+1:0] fwd_x_o,
  output logic signed [UNIT_FRAC_BITS+1:0] fwd_y_o,
  output logic signed [UNIT_FRAC_BITS+1:0] fwd_z_o,
  output logic signed [UNIT_FRAC_BITS+1:0] up_x_o,
  output logic signed [UNIT_FRAC_BITS+1:0] up_y_o,
  output logic signed [UNIT_FRAC_BITS+1:0] up_z_o,
  output logic signed [IN_WIDTH-1:0]       trans_x_o,
  output logic signed [IN_WIDTH-1:0]       trans_y_o,
  output logic signed [IN_WIDTH-1:0]       trans_z_o
);

  logic                      mid_valid;
  logic                      mid_stall;
  logic [IN_WIDTH-1:0]       mid_pos [3];
  logic [IN_WIDTH-1:0]       mid_mag [3];
  cfl_class_t                mid_cls;
  logic [UNIT_FRAC_BITS+1:0] right [2];
  logic [UNIT_FRAC_BITS+1:0] fwd [3];
  logic [UNIT_FRAC_BITS+1:0] up [3];
  logic [IN_WIDTH-1:0]       trans [3];

  // input stage
  cfl_front #(.IN_WIDTH(IN_WIDTH)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .pos_x_i, .pos_y_i, .pos_z_i, .look_x_i, .look_y_i, .look_z_i,
    .valid_o(mid_valid), .stall_i(mid_stall),
    .pos_o(mid_pos), .mag_o(mid_mag), .cls_o(mid_cls)
  );

  // arithmetic pipeline
  cfl_back #(.IN_WIDTH(IN_WIDTH), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .valid_i(mid_valid), .stall_o(mid_stall),
    .pos_i(mid_pos), .mag_i(mid_mag), .cls_i(mid_cls),
    .valid_o, .stall_i,
    .right_o(right), .fwd_o(fwd), .up_o(up), .trans_o(trans)
  );

  assign right_x_o = right[0];
  assign right_y_o = right[1];
  assign right_z_o = 1'b0;
  assign fwd_x_o   = fwd[0];
  assign fwd_y_o   = fwd[1];
  assign fwd_z_o   = fwd[2];
  assign up_x_o    = up[0];
  assign up_y_o    = up[1];
  assign up_z_o    = up[2];
  assign trans_x_o = trans[0];
  assign trans_y_o = trans[1];
  assign trans_z_o = trans[2];

endmodule
